### design/tsme_pkg.sv
// shared constants and codes for the tour segment merge engine
`default_nettype none
package tsme_pkg;

  // fixed widths of result fields
  localparam int LEN_W   = 31;
  localparam int JOIN_W  = 25;
  localparam int KIND_W  = 2;
  localparam int ORI_W   = 3;
  localparam int CMD_W   = 2;
  // Q.8 distance: radicand carries 2*8 fraction bits
  localparam int RAD_FRAC = 16;

  localparam logic [LEN_W-1:0]  LEN_MAX  = {LEN_W{1'b1}};
  localparam logic [JOIN_W-1:0] JOIN_MAX = {JOIN_W{1'b1}};

  // commands
  localparam logic [CMD_W-1:0] CMD_POINT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_MERGE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DROP  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_POINT = 2'd2;

  // splice orientations
  localparam logic [ORI_W-1:0] ORI_FF   = 3'd0;
  localparam logic [ORI_W-1:0] ORI_BF   = 3'd1;
  localparam logic [ORI_W-1:0] ORI_FB   = 3'd2;
  localparam logic [ORI_W-1:0] ORI_BB   = 3'd3;
  localparam logic [ORI_W-1:0] ORI_NONE = 3'd4;

endpackage
`default_nettype wire

### design/tour_segment_merge_engine_core.sv
// top level: path and staging memories with the merge sequencer
// Usage: one input channel (in_valid_i / in_stall_o) carries commands: a
// segment point, a read-out of the main path, or a clear. One output channel
// (out_valid_o / out_stall_i) carries result beats through an output register.
// A segment point after the first gets its edge length from the shared
// distance unit, whose root has ROOTW bits (26 for 16-bit coordinates).
// The point carrying segment_end then runs the merge: a segment too big for
// the path is dropped, else come four endpoint distances if the path holds
// points, each point copied through the staging memory read port and a
// closing distance with two or more path points; then one result beat.
// Read-outs give a beat per path point; clear and unknown commands give none.
// in_stall_o is high while an item is worked on; a pending result in the
// output register does not hold off the next item until a new beat is due.
// When the receiver stalls, the output beat holds and the sequencer waits.
// Reset empties the path and the staging area; memory contents are not
// cleared, as entries are only read after they were written.
`default_nettype none
module tour_segment_merge_engine_core #(
  parameter int MAX_POINTS = 64,
  parameter int COORD_BITS = 16
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  in_valid_i,
  output logic                                       in_stall_o,
  input  wire logic [tsme_pkg::CMD_W-1:0]            command_i,
  input  wire logic signed [COORD_BITS-1:0]          x_coord_i,
  input  wire logic signed [COORD_BITS-1:0]          y_coord_i,
  input  wire logic signed [COORD_BITS-1:0]          z_coord_i,
  input  wire logic                                  segment_end_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_stall_i,
  output logic [tsme_pkg::KIND_W-1:0]                result_kind_o,
  output logic signed [COORD_BITS-1:0]               point_x_o,
  output logic signed [COORD_BITS-1:0]               point_y_o,
  output logic signed [COORD_BITS-1:0]               point_z_o,
  output logic                                       last_of_run_o,
  output logic [tsme_pkg::JOIN_W-1:0]                join_distance_o,
  output logic [tsme_pkg::ORI_W-1:0]                 orientation_o,
  output logic [$clog2(MAX_POINTS+1)-1:0]            point_count_o,
  output logic [tsme_pkg::LEN_W-1:0]                 tour_length_o
);
  import tsme_pkg::*;

  localparam int CB    = COORD_BITS;
  localparam int PW    = 3 * CB;
  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int SC_W  = $clog2(MAX_POINTS + 2);

  typedef enum logic [11:0] {
    S_IDLE     = 12'b000000000001,
    S_SDIST    = 12'b000000000010,
    S_MERGE    = 12'b000000000100,
    S_JOIN     = 12'b000000001000,
    S_COPY_RD  = 12'b000000010000,
    S_COPY_WR  = 12'b000000100000,
    S_FINISH   = 12'b000001000000,
    S_CLOSE_GO = 12'b000010000000,
    S_CLOSE    = 12'b000100000000,
    S_EMIT     = 12'b001000000000,
    S_RD_ADDR  = 12'b010000000000,
    S_RD_EMIT  = 12'b100000000000
  } state_e;

  state_e             state_q, state_d;
  logic [IDX_W-1:0]   head_q, head_d;
  logic [CNT_W-1:0]   pcount_q, pcount_d;
  logic [SC_W-1:0]    scount_q, scount_d;
  logic [LEN_W-1:0]   popen_q, popen_d;
  logic [LEN_W-1:0]   sopen_q, sopen_d;
  logic [LEN_W-1:0]   tour_q, tour_d;
  logic [LEN_W-1:0]   join_q, join_d;
  logic [ORI_W-1:0]   ori_q, ori_d;
  logic [KIND_W-1:0]  kind_q, kind_d;
  logic [1:0]         kidx_q, kidx_d;
  logic [SC_W-1:0]    idx_q, idx_d;
  logic               segend_q, segend_d;
  logic [PW-1:0]      pf_q, pf_d, pb_q, pb_d, sf_q, sf_d, sl_q, sl_d;

  // distance unit request
  logic               dstart_q, dstart_d;
  logic [PW-1:0]      da_q, da_d, db_q, db_d;
  logic               ddone;
  logic [LEN_W-1:0]   dres;

  // output register
  logic               ov_q, ov_d;
  logic [KIND_W-1:0]  okind_q, okind_d;
  logic [PW-1:0]      opt_q, opt_d;
  logic               olast_q, olast_d;
  logic [JOIN_W-1:0]  ojoin_q, ojoin_d;
  logic [ORI_W-1:0]   oori_q, oori_d;
  logic [CNT_W-1:0]   ocnt_q, ocnt_d;
  logic [LEN_W-1:0]   otour_q, otour_d;

  // memories
  logic [PW-1:0]      path_mem [MAX_POINTS];
  logic [PW-1:0]      stg_mem  [MAX_POINTS];
  logic [PW-1:0]      path_rdata_q, stg_rdata_q;
  logic               path_we, stg_we;
  logic [IDX_W-1:0]   path_waddr, path_raddr, stg_waddr, stg_raddr;

  logic               accept, out_free, front, rev;
  logic [PW-1:0]      in_pt;
  logic [IDX_W-1:0]   head_m1;
  logic [SC_W:0]      total;
  logic [1:0]         nk;

  function automatic logic [LEN_W-1:0] sat_add(input logic [LEN_W-1:0] a,
                                               input logic [LEN_W-1:0] b);
    logic [LEN_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[LEN_W] ? LEN_MAX : s[LEN_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] pidx(input logic [IDX_W-1:0] h,
                                            input logic [SC_W-1:0] i);
    logic [SC_W:0] s;
    s = (SC_W+1)'(h) + (SC_W+1)'(i);
    if (s >= (SC_W+1)'(MAX_POINTS)) s = s - (SC_W+1)'(MAX_POINTS);
    return s[IDX_W-1:0];
  endfunction

  tsme_dist #(.COORD_BITS(COORD_BITS)) u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dstart_q),
    .a_i     (da_q),
    .b_i     (db_q),
    .done_o  (ddone),
    .dist_o  (dres)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !ov_q || !out_stall_i;
  assign in_pt      = {x_coord_i, y_coord_i, z_coord_i};
  assign front      = (ori_q == ORI_FF) || (ori_q == ORI_FB);
  assign rev        = (ori_q == ORI_FB) || (ori_q == ORI_BB);
  assign head_m1    = (head_q == '0) ? IDX_W'(MAX_POINTS - 1) : head_q - IDX_W'(1);
  assign total      = (SC_W+1)'(pcount_q) + (SC_W+1)'(scount_q);
  assign nk         = kidx_q + 2'd1;

  // memory addressing
  assign path_raddr = pidx(head_q, idx_q);
  assign stg_raddr  = rev ? IDX_W'(scount_q - idx_q - SC_W'(1)) : idx_q[IDX_W-1:0];
  assign stg_waddr  = scount_q[IDX_W-1:0];
  assign path_waddr = front ? head_m1 : pidx(head_q, SC_W'(pcount_q));

  // sequencer
  always_comb begin
    state_d  = state_q;
    head_d   = head_q;
    pcount_d = pcount_q;
    scount_d = scount_q;
    popen_d  = popen_q;
    sopen_d  = sopen_q;
    tour_d   = tour_q;
    join_d   = join_q;
    ori_d    = ori_q;
    kind_d   = kind_q;
    kidx_d   = kidx_q;
    idx_d    = idx_q;
    segend_d = segend_q;
    pf_d     = pf_q;
    pb_d     = pb_q;
    sf_d     = sf_q;
    sl_d     = sl_q;
    dstart_d = 1'b0;
    da_d     = da_q;
    db_d     = db_q;
    stg_we   = 1'b0;
    path_we  = 1'b0;
    ov_d     = ov_q && out_stall_i;
    okind_d  = okind_q;
    opt_d    = opt_q;
    olast_d  = olast_q;
    ojoin_d  = ojoin_q;
    oori_d   = oori_q;
    ocnt_d   = ocnt_q;
    otour_d  = otour_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (command_i)
            CMD_POINT: begin
              segend_d = segment_end_i;
              state_d  = segment_end_i ? S_MERGE : S_IDLE;
              if (scount_q < SC_W'(MAX_POINTS)) begin
                stg_we   = 1'b1;
                scount_d = scount_q + SC_W'(1);
                sl_d     = in_pt;
                if (scount_q == '0) begin
                  sf_d    = in_pt;
                  sopen_d = '0;
                end else begin
                  dstart_d = 1'b1;
                  da_d     = sl_q;
                  db_d     = in_pt;
                  state_d  = S_SDIST;
                end
              end else if (scount_q == SC_W'(MAX_POINTS)) begin
                scount_d = scount_q + SC_W'(1);
              end
            end
            CMD_READ: begin
              if (pcount_q != '0) begin
                idx_d   = '0;
                state_d = S_RD_ADDR;
              end
            end
            CMD_CLEAR: begin
              head_d   = '0;
              pcount_d = '0;
              popen_d  = '0;
              tour_d   = '0;
            end
            default: ;
          endcase
        end
      end
      // staged edge length
      S_SDIST: begin
        if (ddone) begin
          sopen_d = sat_add(sopen_q, dres);
          state_d = segend_q ? S_MERGE : S_IDLE;
        end
      end
      // capacity check and endpoint choice
      S_MERGE: begin
        if (total > (SC_W+1)'(MAX_POINTS)) begin
          kind_d   = KIND_DROP;
          join_d   = '0;
          ori_d    = ORI_NONE;
          scount_d = '0;
          sopen_d  = '0;
          state_d  = S_EMIT;
        end else if (pcount_q == '0) begin
          kind_d  = KIND_MERGE;
          head_d  = '0;
          join_d  = '0;
          ori_d   = ORI_NONE;
          idx_d   = '0;
          state_d = S_COPY_RD;
        end else begin
          kind_d   = KIND_MERGE;
          kidx_d   = 2'd0;
          dstart_d = 1'b1;
          da_d     = pf_q;
          db_d     = sf_q;
          state_d  = S_JOIN;
        end
      end
      // four endpoint pairs, earlier pair wins a tie
      S_JOIN: begin
        if (ddone) begin
          if (kidx_q == 2'd0 || dres < join_q) begin
            join_d = dres;
            ori_d  = {1'b0, kidx_q};
          end
          if (kidx_q == 2'd3) begin
            idx_d   = '0;
            state_d = S_COPY_RD;
          end else begin
            kidx_d   = nk;
            dstart_d = 1'b1;
            da_d     = nk[0] ? pb_q : pf_q;
            db_d     = nk[1] ? sl_q : sf_q;
          end
        end
      end
      S_COPY_RD: state_d = S_COPY_WR;
      // splice one staged point
      S_COPY_WR: begin
        path_we  = 1'b1;
        pcount_d = pcount_q + CNT_W'(1);
        if (front) head_d = head_m1;
        idx_d = idx_q + SC_W'(1);
        state_d = ((idx_q + SC_W'(1)) == scount_q) ? S_FINISH : S_COPY_RD;
      end
      S_FINISH: begin
        popen_d  = sat_add(sat_add(popen_q, sopen_q), join_q);
        scount_d = '0;
        sopen_d  = '0;
        case (ori_q)
          ORI_FF: pf_d = sl_q;
          ORI_BF: pb_d = sl_q;
          ORI_FB: pf_d = sf_q;
          ORI_BB: pb_d = sf_q;
          default: begin
            pf_d = sf_q;
            pb_d = sl_q;
          end
        endcase
        state_d = S_CLOSE_GO;
      end
      S_CLOSE_GO: begin
        if (pcount_q >= CNT_W'(2)) begin
          dstart_d = 1'b1;
          da_d     = pb_q;
          db_d     = pf_q;
          state_d  = S_CLOSE;
        end else begin
          tour_d  = '0;
          state_d = S_EMIT;
        end
      end
      // closing edge of the tour
      S_CLOSE: begin
        if (ddone) begin
          tour_d  = sat_add(popen_q, dres);
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          ov_d    = 1'b1;
          okind_d = kind_q;
          opt_d   = '0;
          olast_d = 1'b1;
          ojoin_d = (join_q[LEN_W-1:JOIN_W] != '0) ? JOIN_MAX : join_q[JOIN_W-1:0];
          oori_d  = ori_q;
          ocnt_d  = pcount_q;
          otour_d = tour_q;
          state_d = S_IDLE;
        end
      end
      S_RD_ADDR: state_d = S_RD_EMIT;
      // read-out beat
      S_RD_EMIT: begin
        if (out_free) begin
          ov_d    = 1'b1;
          okind_d = KIND_POINT;
          opt_d   = path_rdata_q;
          olast_d = ((idx_q + SC_W'(1)) == SC_W'(pcount_q));
          ojoin_d = '0;
          oori_d  = ORI_NONE;
          ocnt_d  = pcount_q;
          otour_d = tour_q;
          idx_d   = idx_q + SC_W'(1);
          state_d = ((idx_q + SC_W'(1)) == SC_W'(pcount_q)) ? S_IDLE : S_RD_ADDR;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      head_q   <= '0;
      pcount_q <= '0;
      scount_q <= '0;
      popen_q  <= '0;
      sopen_q  <= '0;
      tour_q   <= '0;
      dstart_q <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      pcount_q <= pcount_d;
      scount_q <= scount_d;
      popen_q  <= popen_d;
      sopen_q  <= sopen_d;
      tour_q   <= tour_d;
      dstart_q <= dstart_d;
      ov_q     <= ov_d;
    end
  end

  // working and output payload
  always_ff @(posedge clk_i) begin
    join_q   <= join_d;
    ori_q    <= ori_d;
    kind_q   <= kind_d;
    kidx_q   <= kidx_d;
    idx_q    <= idx_d;
    segend_q <= segend_d;
    pf_q     <= pf_d;
    pb_q     <= pb_d;
    sf_q     <= sf_d;
    sl_q     <= sl_d;
    da_q     <= da_d;
    db_q     <= db_d;
    okind_q  <= okind_d;
    opt_q    <= opt_d;
    olast_q  <= olast_d;
    ojoin_q  <= ojoin_d;
    oori_q   <= oori_d;
    ocnt_q   <= ocnt_d;
    otour_q  <= otour_d;
  end

  // path memory
  always_ff @(posedge clk_i) begin
    if (path_we) path_mem[path_waddr] <= stg_rdata_q;
    path_rdata_q <= path_mem[path_raddr];
  end

  // staging memory
  always_ff @(posedge clk_i) begin
    if (stg_we) stg_mem[stg_waddr] <= in_pt;
    stg_rdata_q <= stg_mem[stg_raddr];
  end

  assign out_valid_o     = ov_q;
  assign result_kind_o   = okind_q;
  assign point_x_o       = opt_q[PW-1:2*CB];
  assign point_y_o       = opt_q[2*CB-1:CB];
  assign point_z_o       = opt_q[CB-1:0];
  assign last_of_run_o   = olast_q;
  assign join_distance_o = ojoin_q;
  assign orientation_o   = oori_q;
  assign point_count_o   = ocnt_q;
  assign tour_length_o   = otour_q;

endmodule
`default_nettype wire

### design/tsme_dist.sv
// iterative euclidean distance unit: three squares then one root bit per cycle
`default_nettype none
module tsme_dist #(
  parameter int COORD_BITS = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [3*COORD_BITS-1:0]     a_i,
  input  wire logic [3*COORD_BITS-1:0]     b_i,
  output logic                             done_o,
  output logic [tsme_pkg::LEN_W-1:0]       dist_o
);
  import tsme_pkg::*;

  localparam int CB     = COORD_BITS;
  localparam int DW     = CB + 1;
  localparam int SQW    = 2 * DW;
  localparam int SUMW   = SQW + 2;
  localparam int RADW0  = SUMW + RAD_FRAC;
  localparam int RADW   = RADW0 + (RADW0 % 2);
  localparam int ROOTW  = RADW / 2;
  localparam int CNTW   = $clog2(ROOTW);

  typedef enum logic [2:0] {
    D_IDLE = 3'b001,
    D_SQ   = 3'b010,
    D_ROOT = 3'b100
  } dstate_e;

  dstate_e            state_q, state_d;
  logic [1:0]         step_q, step_d;
  logic [DW-1:0]      dx_q, dx_d, dy_q, dy_d, dz_q, dz_d;
  logic [SUMW-1:0]    acc_q, acc_d;
  logic [RADW-1:0]    rad_q, rad_d;
  logic [ROOTW+1:0]   rem_q, rem_d;
  logic [ROOTW-1:0]   root_q, root_d;
  logic [CNTW-1:0]    cnt_q, cnt_d;
  logic               done_q, done_d;
  logic [LEN_W-1:0]   dist_q, dist_d;

  logic [DW-1:0]      sq_sel;
  logic [SQW-1:0]     sq_val;
  logic [SUMW-1:0]    acc_sum;
  logic [ROOTW+1:0]   rem_sh, trial;
  logic               ge;

  function automatic logic [DW-1:0] abs_diff(input logic [CB-1:0] a, input logic [CB-1:0] b);
    logic [DW-1:0] d;
    d = {a[CB-1], a} - {b[CB-1], b};
    return d[DW-1] ? (~d + DW'(1)) : d;
  endfunction

  // one squarer shared over the three axes
  always_comb begin
    case (step_q)
      2'd0:    sq_sel = dx_q;
      2'd1:    sq_sel = dy_q;
      default: sq_sel = dz_q;
    endcase
    sq_val  = sq_sel * sq_sel;
    acc_sum = acc_q + SUMW'(sq_val);
  end

  // one restoring root step
  always_comb begin
    rem_sh = {rem_q[ROOTW-1:0], rad_q[RADW-1 -: 2]};
    trial  = {root_q, 2'b01};
    ge     = (rem_sh >= trial);
  end

  // sequencing
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    dx_d    = dx_q;
    dy_d    = dy_q;
    dz_d    = dz_q;
    acc_d   = acc_q;
    rad_d   = rad_q;
    rem_d   = rem_q;
    root_d  = root_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    dist_d  = dist_q;
    case (state_q)
      D_IDLE: begin
        if (start_i) begin
          dx_d    = abs_diff(a_i[3*CB-1:2*CB], b_i[3*CB-1:2*CB]);
          dy_d    = abs_diff(a_i[2*CB-1:CB], b_i[2*CB-1:CB]);
          dz_d    = abs_diff(a_i[CB-1:0], b_i[CB-1:0]);
          acc_d   = '0;
          step_d  = 2'd0;
          state_d = D_SQ;
        end
      end
      D_SQ: begin
        acc_d  = acc_sum;
        step_d = step_q + 2'd1;
        if (step_q == 2'd2) begin
          rad_d   = RADW'({acc_sum, {RAD_FRAC{1'b0}}});
          rem_d   = '0;
          root_d  = '0;
          cnt_d   = CNTW'(ROOTW - 1);
          state_d = D_ROOT;
        end
      end
      D_ROOT: begin
        rem_d  = ge ? (rem_sh - trial) : rem_sh;
        root_d = {root_q[ROOTW-2:0], ge};
        rad_d  = {rad_q[RADW-3:0], 2'b00};
        cnt_d  = cnt_q - CNTW'(1);
        if (cnt_q == '0) begin
          done_d  = 1'b1;
          dist_d  = LEN_W'({root_q[ROOTW-2:0], ge});
          state_d = D_IDLE;
        end
      end
      default: state_d = D_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q <= step_d;
    dx_q   <= dx_d;
    dy_q   <= dy_d;
    dz_q   <= dz_d;
    acc_q  <= acc_d;
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    cnt_q  <= cnt_d;
    dist_q <= dist_d;
  end

  assign done_o = done_q;
  assign dist_o = dist_q;

endmodule
`default_nettype wire

### tb/tour_segment_merge_engine_core_tb.sv
// self-checking bench for the tour segment merge engine: queued driver, beat monitor, path predictor
`default_nettype none
module tour_segment_merge_engine_core_tb;
  import tsme_pkg::*;

  localparam int NPTS = 64;
  localparam int CB = 16;
  localparam int WATCHDOG = 40000;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic signed [CB-1:0] x, y, z;
    logic seg_end;
  } cmd_beat_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic signed [CB-1:0] x, y, z;
    logic last;
    logic [JOIN_W-1:0] join_d;
    logic [ORI_W-1:0] ori;
    logic [6:0] count;
    logic [LEN_W-1:0] tour;
  } result_beat_t;

  typedef struct packed {
    logic signed [CB-1:0] x, y, z;
  } point_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [CMD_W-1:0] command_i = '0;
  logic signed [CB-1:0] x_coord_i = '0, y_coord_i = '0, z_coord_i = '0;
  logic segment_end_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [KIND_W-1:0] result_kind_o;
  logic signed [CB-1:0] point_x_o, point_y_o, point_z_o;
  logic last_of_run_o;
  logic [JOIN_W-1:0] join_distance_o;
  logic [ORI_W-1:0] orientation_o;
  logic [6:0] point_count_o;
  logic [LEN_W-1:0] tour_length_o;

  tour_segment_merge_engine_core #(.MAX_POINTS(NPTS), .COORD_BITS(CB)) u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .command_i, .x_coord_i,
    .y_coord_i, .z_coord_i, .segment_end_i, .out_valid_o, .out_stall_i,
    .result_kind_o, .point_x_o, .point_y_o, .point_z_o, .last_of_run_o,
    .join_distance_o, .orientation_o, .point_count_o, .tour_length_o
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // predictor state
  point_t path_mem[NPTS];
  point_t stage_mem[NPTS];
  int unsigned head_q, path_n, stage_n;
  logic [LEN_W-1:0] path_len, stage_len;

  cmd_beat_t pending_cmds[$];
  result_beat_t expected_results[$];
  int send_idle_pct = 0, recv_stall_pct = 0;
  bit hold_off = 1'b0;
  int mismatches = 0, beats_seen = 0, cmds_sent = 0, quiet_cycles = 0;
  int merges_seen = 0, drops_seen = 0;

  function automatic longint unsigned int_root(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [LEN_W-1:0] edge_q8(point_t a, point_t b);
    longint dx, dy, dz;
    longint unsigned s, r;
    dx = longint'(a.x) - longint'(b.x);
    dy = longint'(a.y) - longint'(b.y);
    dz = longint'(a.z) - longint'(b.z);
    s = dx * dx + dy * dy + dz * dz;
    r = int_root(s << RAD_FRAC);
    return (r > LEN_MAX) ? LEN_MAX : r[LEN_W-1:0];
  endfunction

  function automatic logic [LEN_W-1:0] add_sat(logic [LEN_W-1:0] a, logic [LEN_W-1:0] b);
    logic [LEN_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[LEN_W] ? LEN_MAX : s[LEN_W-1:0];
  endfunction

  function automatic int unsigned slot(int unsigned i);
    return (head_q + i) % NPTS;
  endfunction

  function automatic logic [LEN_W-1:0] closed_tour();
    if (path_n < 2) return '0;
    return add_sat(path_len, edge_q8(path_mem[slot(path_n - 1)], path_mem[slot(0)]));
  endfunction

  task automatic push_result(logic [KIND_W-1:0] kind, point_t p, logic last,
                             logic [LEN_W-1:0] jd, logic [ORI_W-1:0] ori);
    result_beat_t r;
    r.kind = kind;
    r.x = p.x;
    r.y = p.y;
    r.z = p.z;
    r.last = last;
    r.join_d = (jd > JOIN_MAX) ? JOIN_MAX : jd[JOIN_W-1:0];
    r.ori = ori;
    r.count = path_n[6:0];
    r.tour = closed_tour();
    expected_results.push_back(r);
  endtask

  task automatic add_front(point_t p);
    head_q = (head_q + NPTS - 1) % NPTS;
    path_mem[head_q] = p;
    path_n++;
  endtask

  task automatic add_back(point_t p);
    path_mem[slot(path_n)] = p;
    path_n++;
  endtask

  // splice staged segment into the main path, or drop it if it does not fit
  task automatic merge_segment();
    point_t zp, pf, pb, sf, sb;
    logic [LEN_W-1:0] jd, d;
    logic [ORI_W-1:0] ori;
    int unsigned n;
    zp = '0;
    n = stage_n;
    jd = '0;
    ori = ORI_NONE;
    if (path_n + n > NPTS) begin
      stage_n = 0;
      stage_len = '0;
      push_result(KIND_DROP, zp, 1'b1, '0, ORI_NONE);
      return;
    end
    if (path_n == 0) begin
      head_q = 0;
      for (int i = 0; i < n; i++) path_mem[i] = stage_mem[i];
      path_n = n;
      path_len = stage_len;
    end else begin
      pf = path_mem[slot(0)];
      pb = path_mem[slot(path_n - 1)];
      sf = stage_mem[0];
      sb = stage_mem[n - 1];
      jd = edge_q8(pf, sf);
      ori = ORI_FF;
      d = edge_q8(pb, sf);
      if (d < jd) begin jd = d; ori = ORI_BF; end
      d = edge_q8(pf, sb);
      if (d < jd) begin jd = d; ori = ORI_FB; end
      d = edge_q8(pb, sb);
      if (d < jd) begin jd = d; ori = ORI_BB; end
      for (int i = 0; i < n; i++) begin
        case (ori)
          ORI_FF: add_front(stage_mem[i]);
          ORI_BF: add_back(stage_mem[i]);
          ORI_FB: add_front(stage_mem[n - 1 - i]);
          default: add_back(stage_mem[n - 1 - i]);
        endcase
      end
      path_len = add_sat(add_sat(path_len, stage_len), jd);
    end
    stage_n = 0;
    stage_len = '0;
    push_result(KIND_MERGE, zp, 1'b1, jd, ori);
  endtask

  task automatic predict(cmd_beat_t c);
    point_t p;
    p.x = c.x;
    p.y = c.y;
    p.z = c.z;
    case (c.cmd)
      CMD_POINT: begin
        if (stage_n < NPTS) begin
          stage_mem[stage_n] = p;
          stage_len = (stage_n > 0) ? add_sat(stage_len, edge_q8(stage_mem[stage_n - 1], p)) : '0;
          stage_n++;
        end else if (stage_n == NPTS) begin
          stage_n++;
        end
        if (c.seg_end) merge_segment();
      end
      CMD_READ: begin
        for (int i = 0; i < path_n; i++)
          push_result(KIND_POINT, path_mem[slot(i)], (i + 1 == path_n), '0, ORI_NONE);
      end
      CMD_CLEAR: begin
        head_q = 0;
        path_n = 0;
        path_len = '0;
      end
      default: ;
    endcase
  endtask

  // driver: offers the next queued beat, holds it while stalled
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predict({command_i, x_coord_i, y_coord_i, z_coord_i, segment_end_i});
        cmds_sent++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cmd_beat_t c;
          c = pending_cmds.pop_front();
          in_valid_i <= 1'b1;
          command_i <= c.cmd;
          x_coord_i <= c.x;
          y_coord_i <= c.y;
          z_coord_i <= c.z;
          segment_end_i <= c.seg_end;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern
  always @(posedge clk_i) begin
    out_stall_i <= hold_off || ($urandom_range(99) < recv_stall_pct);
  end

  // monitor: compares each result beat with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG) begin
        $display("watchdog: no progress, %0d results outstanding", expected_results.size());
        $display("end of test: mismatches");
        $finish;
      end
      if (out_valid_o && !out_stall_i) begin
        result_beat_t got, exp_r;
        got = {result_kind_o, point_x_o, point_y_o, point_z_o, last_of_run_o,
               join_distance_o, orientation_o, point_count_o, tour_length_o};
        beats_seen++;
        if (result_kind_o == KIND_MERGE) merges_seen++;
        if (result_kind_o == KIND_DROP) drops_seen++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat %p", got);
        end else begin
          exp_r = expected_results.pop_front();
          if (got !== exp_r) begin
            mismatches++;
            if (mismatches <= 10) $display("beat %0d mismatch\n  exp %p\n  got %p",
                                           beats_seen, exp_r, got);
          end
        end
      end
    end
  end

  function automatic cmd_beat_t make_point(int x, int y, int z, bit e);
    cmd_beat_t c;
    c.cmd = CMD_POINT;
    c.x = CB'(x);
    c.y = CB'(y);
    c.z = CB'(z);
    c.seg_end = e;
    return c;
  endfunction

  function automatic cmd_beat_t make_cmd(logic [CMD_W-1:0] k);
    cmd_beat_t c;
    c = '0;
    c.cmd = k;
    c.x = CB'($urandom);
    c.y = CB'($urandom);
    c.z = CB'($urandom);
    c.seg_end = 1'($urandom_range(1));
    return c;
  endfunction

  function automatic int rnd_coord(bit wide);
    return wide ? int'($urandom_range(65535)) - 32768 : int'($urandom_range(200)) - 100;
  endfunction

  task automatic queue_segment(int len, bit wide);
    for (int i = 0; i < len; i++)
      pending_cmds.push_back(make_point(rnd_coord(wide), rnd_coord(wide), rnd_coord(wide),
                                        i == len - 1));
  endtask

  task automatic drain();
    while (pending_cmds.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic random_phase(int count);
    int r;
    for (int k = 0; k < count; ) begin
      r = $urandom_range(99);
      if (r < 70) begin
        int len;
        len = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
        queue_segment(len, $urandom_range(3) == 0);
        k += len;
      end else if (r < 82) begin
        pending_cmds.push_back(make_cmd(CMD_READ));
        k++;
      end else if (r < 90) begin
        pending_cmds.push_back(make_cmd(CMD_CLEAR));
        k++;
      end else if (r < 94) begin
        pending_cmds.push_back(make_cmd(2'd3));
      end else begin
        pending_cmds.push_back(make_point(rnd_coord(1'b1), rnd_coord(1'b1), rnd_coord(1'b1),
                                          1'b0));
        k++;
      end
    end
  endtask

  initial begin
    head_q = 0;
    path_n = 0;
    stage_n = 0;
    path_len = '0;
    stage_len = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty read, extremes, orientations FF, BF and FB, ties, unknown command
    pending_cmds.push_back(make_cmd(CMD_READ));
    pending_cmds.push_back(make_point(-32768, 32767, -32768, 1'b0));
    pending_cmds.push_back(make_point(32767, -32768, 32767, 1'b1));
    pending_cmds.push_back(make_point(32767, -32768, 32767, 1'b1));
    pending_cmds.push_back(make_point(-32768, 32767, -32768, 1'b1));
    pending_cmds.push_back(make_cmd(CMD_READ));
    pending_cmds.push_back(make_cmd(CMD_CLEAR));
    pending_cmds.push_back(make_point(0, 0, 0, 1'b0));
    pending_cmds.push_back(make_point(10, 0, 0, 1'b1));
    pending_cmds.push_back(make_point(20, 0, 0, 1'b0));
    pending_cmds.push_back(make_point(30, 0, 0, 1'b1));
    pending_cmds.push_back(make_point(-30, 0, 0, 1'b0));
    pending_cmds.push_back(make_point(-10, 0, 0, 1'b1));
    pending_cmds.push_back(make_point(5, 1, 0, 1'b1));
    pending_cmds.push_back(make_cmd(2'd3));
    pending_cmds.push_back(make_cmd(CMD_READ));
    pending_cmds.push_back(make_cmd(CMD_CLEAR));
    pending_cmds.push_back(make_point(1, 1, 1, 1'b1));
    drain();
    // staging overflow: 66 points, then capacity overflow against a full path
    queue_segment(66, 1'b0);
    queue_segment(64, 1'b0);
    queue_segment(1, 1'b0);
    pending_cmds.push_back(make_cmd(CMD_READ));
    pending_cmds.push_back(make_cmd(CMD_CLEAR));
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 36 : 59) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 36 : 59) : 0;
      random_phase(10);
      if (ph == 1) begin
        // long receiver hold-off while the sender keeps offering
        pending_cmds.push_back(make_cmd(CMD_READ));
        pending_cmds.push_back(make_cmd(CMD_READ));
        queue_segment(3, 1'b0);
        hold_off = 1'b1;
        repeat (400) @(posedge clk_i);
        hold_off = 1'b0;
      end
      drain();
    end

    $display("sent %0d commands, checked %0d result beats (%0d merges, %0d drops)",
             cmds_sent, beats_seen, merges_seen, drops_seen);
    $display("mismatch count %0d", mismatches);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
`default_nettype wire
